@@ rtl/core/cps_pkg.sv @@
// ----------------------------------------------------------------------------
// cps_pkg
// Shared widths, register indexes, state codes and the project record layout
// for the critical path scheduler.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int MAX_PROJECTS_DEF = 64;

  localparam int PRED_W = 6;
  localparam int DUR_W  = 12;
  localparam int ERL_W  = 18;
  localparam int HOR_W  = 16;
  localparam int MSUC_W = 17;
  localparam int TOT_W  = 7;
  localparam int PIDX_W = 7;
  localparam int LAT_W  = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 1'b1;

  localparam logic [HOR_W-1:0] HORIZON_RST = 16'd365;
  localparam logic [TOT_W-1:0] TOTAL_RST   = 7'd64;

  // in_tdata: predecessor, duration, zero pad to 24 bits
  localparam int IN_DATA_W  = 24;
  // out_tdata: project_index, earliest_start, latest_start, latest_valid, pad to 48 bits
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic [ERL_W-1:0]  earliest;
    logic [DUR_W-1:0]  dur;
    logic [PRED_W-1:0] pred;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_WR,
    ST_REV_RD,
    ST_REV_CALC,
    ST_REV_UPD,
    ST_EMIT_RD,
    ST_EMIT_CAP
  } state_t;

endpackage

@@ rtl/core/cps_ram.sv @@
// ----------------------------------------------------------------------------
// cps_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/critical_path_schedule.sv @@
// ----------------------------------------------------------------------------
// critical_path_schedule
// Loads a batch of projects (at most one predecessor each), computes earliest start
// on load, runs a reverse pass for latest start if feasible, emits one word per project.
//
//   channel | dir | handshake        | payload
//   in_     | in  | tvalid/tready    | tdata: predecessor, duration
//   out_    | out | tvalid/tready    | tdata: index, earliest, latest, valid; tlast
//   cfg_    | in  | wr_en            | index, wr_data (horizon_days, project_total)
//
// load: per project, pred record read as it is taken, then write of the new record
// reverse pass: per project, read then calc, plus a min update when it has a predecessor
// emission: per result, a read then a capture, plus any stall on out_tready
// synchronous active-low reset; no memory clearing pass is needed
// a pending result in the output register does not block the next load
// ----------------------------------------------------------------------------
module critical_path_schedule #(
  parameter int MAX_PROJECTS = cps_pkg::MAX_PROJECTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cps_pkg::IN_DATA_W-1:0]  in_tdata,   // [5:0] predecessor, [17:6] duration
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cps_pkg::OUT_DATA_W-1:0] out_tdata,  // [6:0] index, [24:7] earliest,
                                                     // [40:25] latest, [41] latest_valid
  output logic                           out_tlast,
  input  logic                           cfg_wr_en,
  input  logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cps_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import cps_pkg::*;

  localparam int AW    = $clog2(MAX_PROJECTS);
  localparam int CNT_W = $clog2(MAX_PROJECTS + 1);

  // configuration
  logic [HOR_W-1:0] horizon_r;
  logic [TOT_W-1:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r <= HORIZON_RST;
      total_r   <= TOTAL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HORIZON: horizon_r <= cfg_wr_data[HOR_W-1:0];
        CFG_TOTAL:   total_r   <= cfg_wr_data[TOT_W-1:0];
        default: ;
      endcase
    end
  end

  // state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   load_count_r, load_count_nxt;
  logic [CNT_W-1:0]   cursor_r, cursor_nxt;
  logic               feasible_r, feasible_nxt;
  logic [PRED_W-1:0]  pred_r, pred_nxt;
  logic [DUR_W-1:0]   dur_r, dur_nxt;
  logic               root_r, root_nxt;
  logic [PRED_W-1:0]  upd_pred_r, upd_pred_nxt;
  logic [LAT_W-1:0]   lat_r, lat_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  // memories
  logic              rec_wr_en;
  logic [AW-1:0]     rec_wr_addr, rec_rd_addr;
  rec_t              rec_wr, rec_rd;
  logic [REC_W-1:0]  rec_rd_raw;
  logic              ms_wr_en;
  logic [AW-1:0]     ms_wr_addr, ms_rd_addr;
  logic [MSUC_W-1:0] ms_wr_data, ms_rd_data;

  cps_ram #(.WIDTH(REC_W), .DEPTH(MAX_PROJECTS)) u_rec_ram (
    .clk     (clk),
    .wr_en   (rec_wr_en),
    .wr_addr (rec_wr_addr),
    .wr_data (rec_wr),
    .rd_addr (rec_rd_addr),
    .rd_data (rec_rd_raw)
  );

  // min-successor store; after the reverse pass an entry holds its latest start
  cps_ram #(.WIDTH(MSUC_W), .DEPTH(MAX_PROJECTS)) u_msuc_ram (
    .clk     (clk),
    .wr_en   (ms_wr_en),
    .wr_addr (ms_wr_addr),
    .wr_data (ms_wr_data),
    .rd_addr (ms_rd_addr),
    .rd_data (ms_rd_data)
  );

  assign rec_rd = rec_t'(rec_rd_raw);

  // combinational helpers
  logic [PRED_W-1:0] in_pred;
  logic [DUR_W-1:0]  in_dur;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  cursor_m1;
  logic [7:0]        tot_eff;
  logic [ERL_W-1:0]  earliest;
  logic [ERL_W:0]    end_day;
  logic [MSUC_W-1:0] hz_plus1;
  logic [MSUC_W-1:0] lat_full;
  logic [LAT_W-1:0]  lat_sat;
  logic              in_acc;
  logic              out_free;

  assign in_pred   = in_tdata[PRED_W-1:0];
  assign in_dur    = in_tdata[PRED_W+DUR_W-1:PRED_W];
  assign idx       = load_count_r + CNT_W'(1);
  assign cursor_m1 = cursor_r - CNT_W'(1);
  assign hz_plus1  = MSUC_W'(horizon_r) + MSUC_W'(1);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    tot_eff = 8'(total_r);
    if (tot_eff == 8'd0) begin
      tot_eff = 8'd1;
    end
    if (tot_eff > 8'(MAX_PROJECTS)) begin
      tot_eff = 8'(MAX_PROJECTS);
    end
  end

  assign earliest = root_r ? ERL_W'(1) : ERL_W'(rec_rd.earliest + ERL_W'(rec_rd.dur));
  assign end_day  = (ERL_W+1)'(earliest) + (ERL_W+1)'(dur_r);

  always_comb begin
    if (ms_rd_data > MSUC_W'(rec_rd.dur)) begin
      lat_full = ms_rd_data - MSUC_W'(rec_rd.dur);
    end else begin
      lat_full = '0;
    end
    lat_sat = lat_full[MSUC_W-1] ? {LAT_W{1'b1}} : lat_full[LAT_W-1:0];
  end

  always_comb begin
    state_nxt      = state_r;
    load_count_nxt = load_count_r;
    cursor_nxt     = cursor_r;
    feasible_nxt   = feasible_r;
    pred_nxt       = pred_r;
    dur_nxt        = dur_r;
    root_nxt       = root_r;
    upd_pred_nxt   = upd_pred_r;
    lat_nxt        = lat_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;

    rec_wr_en   = 1'b0;
    rec_wr_addr = idx[AW-1:0] - AW'(1);
    rec_wr      = '{earliest: earliest, dur: dur_r, pred: root_r ? '0 : pred_r};
    rec_rd_addr = cursor_m1[AW-1:0];
    ms_wr_en    = 1'b0;
    ms_wr_addr  = idx[AW-1:0] - AW'(1);
    ms_wr_data  = hz_plus1;
    ms_rd_addr  = cursor_m1[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        // fetch the predecessor record while the new project is taken
        if (in_pred == '0 || 8'(in_pred) >= 8'(idx)) begin
          rec_rd_addr = '0;
        end else begin
          rec_rd_addr = AW'(in_pred - PRED_W'(1));
        end
        if (in_acc) begin
          pred_nxt  = in_pred;
          dur_nxt   = in_dur;
          root_nxt  = (in_pred == '0) || (8'(in_pred) >= 8'(idx));
          state_nxt = ST_LD_WR;
        end
      end
      ST_LD_WR: begin
        rec_wr_en = 1'b1;
        ms_wr_en  = 1'b1;
        if (end_day > (ERL_W+1)'(hz_plus1)) begin
          feasible_nxt = 1'b0;
        end
        load_count_nxt = idx;
        if (8'(idx) >= tot_eff) begin
          if (feasible_nxt) begin
            cursor_nxt = idx;
            state_nxt  = ST_REV_RD;
          end else begin
            cursor_nxt = CNT_W'(1);
            state_nxt  = ST_EMIT_RD;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REV_RD: begin
        state_nxt = ST_REV_CALC;
      end
      ST_REV_CALC: begin
        ms_wr_en     = 1'b1;
        ms_wr_addr   = cursor_m1[AW-1:0];
        ms_wr_data   = MSUC_W'(lat_sat);
        lat_nxt      = lat_sat;
        upd_pred_nxt = rec_rd.pred;
        ms_rd_addr   = AW'(rec_rd.pred - PRED_W'(1));
        if (rec_rd.pred != '0) begin
          state_nxt = ST_REV_UPD;
        end else if (cursor_r == CNT_W'(1)) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          cursor_nxt = cursor_m1;
          state_nxt  = ST_REV_RD;
        end
      end
      ST_REV_UPD: begin
        // fold this latest start into the predecessor's successor minimum
        ms_rd_addr = AW'(upd_pred_r - PRED_W'(1));
        ms_wr_addr = AW'(upd_pred_r - PRED_W'(1));
        ms_wr_data = MSUC_W'(lat_r);
        ms_wr_en   = MSUC_W'(lat_r) < ms_rd_data;
        if (cursor_r == CNT_W'(1)) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          cursor_nxt = cursor_m1;
          state_nxt  = ST_REV_RD;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_CAP;
      end
      ST_EMIT_CAP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({feasible_r,
                                       feasible_r ? ms_rd_data[LAT_W-1:0] : LAT_W'(0),
                                       rec_rd.earliest,
                                       PIDX_W'(cursor_r)});
          out_last_nxt  = (cursor_r == load_count_r);
          if (cursor_r == load_count_r) begin
            load_count_nxt = '0;
            feasible_nxt   = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            cursor_nxt = cursor_r + CNT_W'(1);
            state_nxt  = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      load_count_r <= '0;
      cursor_r     <= '0;
      feasible_r   <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_count_r <= load_count_nxt;
      cursor_r     <= cursor_nxt;
      feasible_r   <= feasible_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pred_r     <= pred_nxt;
    dur_r      <= dur_nxt;
    root_r     <= root_nxt;
    upd_pred_r <= upd_pred_nxt;
    lat_r      <= lat_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_accept_to_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_LD_WR)
    else $error("accepted project not followed by record write");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_count_r <= CNT_W'(MAX_PROJECTS))
    else $error("load count beyond capacity");

  a_pred_below: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REV_UPD |-> CNT_W'(upd_pred_r) < cursor_r)
    else $error("reverse pass update targets a non-earlier project");

  a_emit_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_CAP |-> cursor_r != '0 && cursor_r <= load_count_r)
    else $error("emission index outside loaded batch");
`endif

endmodule
